### src/rc4ks_pkg.sv
// ============================================================================
// rc4ks_pkg
// Shared types and constants for the RC4 keystream cipher engine: operation
// codes, sequencer states, memory sizes and the S-box port control bundle.
// ============================================================================
package rc4ks_pkg;

    // The S-box is a full byte permutation: its size follows from the byte width.
    localparam int SBOX_AW   = 8;
    localparam int SBOX_SIZE = 1 << SBOX_AW;

    // Depth of the key store, between 1 and 256 bytes.
    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_CW    = $clog2(KEY_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CRYPT  = 2'd1,
        OP_INVERT = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CR_J,
        ST_CR_T,
        ST_CR_OUT,
        ST_KS_N,
        ST_KS_J,
        ST_KS_SW,
        ST_KS_FIN
    } state_t;

    // One access slot of the S-box store per cycle: one read and one write.
    typedef struct packed {
        logic               re;
        logic [SBOX_AW-1:0] raddr;
        logic               we;
        logic [SBOX_AW-1:0] waddr;
        logic [SBOX_AW-1:0] wdata;
        logic               clear;
        logic               invert;
    } sbox_ctl_t;

endpackage

### src/rc4ks_sbox.sv
// ============================================================================
// rc4ks_sbox
// S-box store: a synchronous memory with one write and one registered read
// port, per-entry valid bits that make unwritten entries read as the identity
// permutation, a global complement flag and a same-cycle write bypass.
// ============================================================================
module rc4ks_sbox
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rc4ks_pkg::sbox_ctl_t         ctl,
    output logic [rc4ks_pkg::SBOX_AW-1:0] rdata
);

    logic [rc4ks_pkg::SBOX_AW-1:0]   mem [rc4ks_pkg::SBOX_SIZE];
    logic [rc4ks_pkg::SBOX_SIZE-1:0] valid_reg;
    logic [rc4ks_pkg::SBOX_SIZE-1:0] valid_next;
    logic                            inv_reg;
    logic                            inv_next;
    logic [rc4ks_pkg::SBOX_AW-1:0]   mem_rd_reg;
    logic [rc4ks_pkg::SBOX_AW-1:0]   raddr_reg;
    logic [rc4ks_pkg::SBOX_AW-1:0]   byp_data_reg;
    logic                            vld_rd_reg;
    logic                            byp_reg;
    logic [rc4ks_pkg::SBOX_AW-1:0]   inv_mask;

    assign inv_mask = {rc4ks_pkg::SBOX_AW{inv_reg}};

    always_comb
    begin
        valid_next = valid_reg;
        inv_next   = inv_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
            inv_next   = 1'b0;
        end
        else
        begin
            if (ctl.we)
            begin
                valid_next[ctl.waddr] = 1'b1;
            end
            if (ctl.invert)
            begin
                inv_next = ~inv_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            inv_reg    <= 1'b0;
            vld_rd_reg <= 1'b0;
            byp_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            inv_reg   <= inv_next;
            if (ctl.re)
            begin
                vld_rd_reg <= valid_reg[ctl.raddr];
                byp_reg    <= ctl.we && (ctl.waddr == ctl.raddr);
            end
        end
    end

    // Entries are stored in physical form: the logical value XOR the flag.
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata ^ inv_mask;
        end
        if (ctl.re)
        begin
            mem_rd_reg   <= mem[ctl.raddr];
            raddr_reg    <= ctl.raddr;
            byp_data_reg <= ctl.wdata;
        end
    end

    assign rdata = byp_reg ? byp_data_reg
                           : ((vld_rd_reg ? mem_rd_reg : raddr_reg) ^ inv_mask);

endmodule

### src/rc4_keystream_cipher.sv
// ============================================================================
// rc4_keystream_cipher
// RC4 engine with key loading, key schedule, byte encryption and a whole
// S-box complement operation, built around a single-write-port S-box memory.
// ============================================================================
//
//  Channel | Signals                                      | Direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_stall, operation, data_byte,    | in (stall out)
//          | last_key_byte                                |
//  output  | out_valid, out_stall, out_byte               | out (stall in)
//
// A crypt transaction occupies the engine: the S-box memory is read for
// S[i], then S[j], then the keystream entry, and the two halves of the swap
// go through its single write port in the ST_CR_T and ST_CR_OUT states.
// Key loads, inversions and unused operation codes are taken in the idle state.
// A load flagged as the last key byte runs the key schedule: states ST_KS_N,
// ST_KS_J and ST_KS_SW for each of the 256 entries, then one closing write.
// Reset gives the identity S-box at once through per-entry valid bits, so no
// clearing pass is needed. A stalled result holds the engine in its final
// crypt cycle, while loads and inversions are still taken when one waits.
//
module rc4_keystream_cipher
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] data_byte,
    input  logic       last_key_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte
);

    rc4ks_pkg::state_t                state_reg;
    rc4ks_pkg::state_t                state_next;
    logic [rc4ks_pkg::SBOX_AW-1:0]    i_reg;
    logic [rc4ks_pkg::SBOX_AW-1:0]    i_next;
    logic [rc4ks_pkg::SBOX_AW-1:0]    j_reg;
    logic [rc4ks_pkg::SBOX_AW-1:0]    j_next;
    logic [rc4ks_pkg::SBOX_AW-1:0]    n_reg;
    logic [rc4ks_pkg::SBOX_AW-1:0]    n_next;
    logic [rc4ks_pkg::KEY_CW-1:0]     key_count_reg;
    logic [rc4ks_pkg::KEY_CW-1:0]     key_count_next;
    logic [rc4ks_pkg::KEY_AW-1:0]     kpos_reg;
    logic [rc4ks_pkg::KEY_AW-1:0]     kpos_next;
    logic                             pend_reg;
    logic                             pend_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [7:0]                       out_byte_reg;
    logic [7:0]                       out_byte_next;
    logic [rc4ks_pkg::SBOX_AW-1:0]    si_reg;
    logic [rc4ks_pkg::SBOX_AW-1:0]    si_next;
    logic [rc4ks_pkg::SBOX_AW-1:0]    sj_reg;
    logic [rc4ks_pkg::SBOX_AW-1:0]    sj_next;
    logic [rc4ks_pkg::SBOX_AW-1:0]    t_reg;
    logic [rc4ks_pkg::SBOX_AW-1:0]    t_next;
    logic [7:0]                       data_reg;
    logic [7:0]                       data_next;

    logic [7:0]                       key_mem [rc4ks_pkg::KEY_DEPTH];
    logic [7:0]                       key_rd_reg;
    logic                             key_we;
    logic                             key_re;
    logic                             key_full;
    logic [rc4ks_pkg::KEY_CW-1:0]     kpos_inc;

    rc4ks_pkg::sbox_ctl_t             sbox_ctl;
    logic [rc4ks_pkg::SBOX_AW-1:0]    sbox_rd;
    logic [rc4ks_pkg::SBOX_AW-1:0]    j_sched;
    logic [rc4ks_pkg::SBOX_AW-1:0]    ks;

    rc4ks_sbox u_sbox
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sbox_ctl),
        .rdata (sbox_rd)
    );

    assign key_full = (key_count_reg == rc4ks_pkg::KEY_CW'(rc4ks_pkg::KEY_DEPTH));
    assign kpos_inc = rc4ks_pkg::KEY_CW'(kpos_reg) + 1'b1;
    assign j_sched  = j_reg + sbox_rd + key_rd_reg;
    // When the keystream index hits i, the memory still holds the old S[i];
    // its new value is the S[j] captured in the ST_CR_T state.
    assign ks       = (t_reg == i_reg) ? sj_reg : sbox_rd;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        key_count_next = key_count_reg;
        kpos_next      = kpos_reg;
        pend_next      = pend_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        sbox_ctl       = '0;
        key_we         = 1'b0;
        key_re         = 1'b0;
        in_stall       = 1'b1;

        case (state_reg)
            rc4ks_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (operation)
                        rc4ks_pkg::OP_LOAD:
                        begin
                            if (!key_full)
                            begin
                                key_we         = 1'b1;
                                key_count_next = key_count_reg + 1'b1;
                            end
                            if (last_key_byte)
                            begin
                                sbox_ctl.clear = 1'b1;
                                i_next         = '0;
                                j_next         = '0;
                                n_next         = '0;
                                kpos_next      = '0;
                                pend_next      = 1'b0;
                                state_next     = rc4ks_pkg::ST_KS_N;
                            end
                        end
                        rc4ks_pkg::OP_CRYPT:
                        begin
                            i_next         = i_reg + 1'b1;
                            sbox_ctl.re    = 1'b1;
                            sbox_ctl.raddr = i_reg + 1'b1;
                            data_next      = data_byte;
                            state_next     = rc4ks_pkg::ST_CR_J;
                        end
                        rc4ks_pkg::OP_INVERT:
                        begin
                            sbox_ctl.invert = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rc4ks_pkg::ST_CR_J:
            begin
                si_next        = sbox_rd;
                j_next         = j_reg + sbox_rd;
                sbox_ctl.re    = 1'b1;
                sbox_ctl.raddr = j_reg + sbox_rd;
                state_next     = rc4ks_pkg::ST_CR_T;
            end
            rc4ks_pkg::ST_CR_T:
            begin
                sj_next        = sbox_rd;
                t_next         = si_reg + sbox_rd;
                sbox_ctl.we    = 1'b1;
                sbox_ctl.waddr = j_reg;
                sbox_ctl.wdata = si_reg;
                sbox_ctl.re    = 1'b1;
                sbox_ctl.raddr = si_reg + sbox_rd;
                state_next     = rc4ks_pkg::ST_CR_OUT;
            end
            rc4ks_pkg::ST_CR_OUT:
            begin
                sbox_ctl.we    = 1'b1;
                sbox_ctl.waddr = i_reg;
                sbox_ctl.wdata = sj_reg;
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks;
                    state_next     = rc4ks_pkg::ST_IDLE;
                end
            end
            rc4ks_pkg::ST_KS_N:
            begin
                sbox_ctl.re    = 1'b1;
                sbox_ctl.raddr = n_reg;
                key_re         = 1'b1;
                if (pend_reg)
                begin
                    sbox_ctl.we    = 1'b1;
                    sbox_ctl.waddr = j_reg;
                    sbox_ctl.wdata = si_reg;
                end
                state_next = rc4ks_pkg::ST_KS_J;
            end
            rc4ks_pkg::ST_KS_J:
            begin
                si_next        = sbox_rd;
                j_next         = j_sched;
                sbox_ctl.re    = 1'b1;
                sbox_ctl.raddr = j_sched;
                state_next     = rc4ks_pkg::ST_KS_SW;
            end
            rc4ks_pkg::ST_KS_SW:
            begin
                sbox_ctl.we    = 1'b1;
                sbox_ctl.waddr = n_reg;
                sbox_ctl.wdata = sbox_rd;
                pend_next      = 1'b1;
                n_next         = n_reg + 1'b1;
                if (kpos_inc >= key_count_reg)
                begin
                    kpos_next = '0;
                end
                else
                begin
                    kpos_next = kpos_inc[rc4ks_pkg::KEY_AW-1:0];
                end
                if (n_reg == rc4ks_pkg::SBOX_AW'(rc4ks_pkg::SBOX_SIZE - 1))
                begin
                    state_next = rc4ks_pkg::ST_KS_FIN;
                end
                else
                begin
                    state_next = rc4ks_pkg::ST_KS_N;
                end
            end
            rc4ks_pkg::ST_KS_FIN:
            begin
                sbox_ctl.we    = 1'b1;
                sbox_ctl.waddr = j_reg;
                sbox_ctl.wdata = si_reg;
                i_next         = '0;
                j_next         = '0;
                key_count_next = '0;
                pend_next      = 1'b0;
                state_next     = rc4ks_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rc4ks_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4ks_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            key_count_reg <= '0;
            kpos_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            key_count_reg <= key_count_next;
            kpos_reg      <= kpos_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
    end

    // Key store: written by loads, read once per schedule step.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_count_reg[rc4ks_pkg::KEY_AW-1:0]] <= data_byte;
        end
        if (key_re)
        begin
            key_rd_reg <= key_mem[kpos_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // A result only appears at the end of a crypt sequence.
    a_out_from_crypt: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rc4ks_pkg::ST_CR_OUT))
        else $error("result raised outside the final crypt cycle");

    // The key length never exceeds the store depth.
    a_key_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= rc4ks_pkg::KEY_CW'(rc4ks_pkg::KEY_DEPTH))
        else $error("key count beyond key store depth");

    // The schedule ends with both indices and the key count at zero.
    a_sched_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4ks_pkg::ST_KS_FIN) |=>
            (i_reg == '0 && j_reg == '0 && key_count_reg == '0
             && state_reg == rc4ks_pkg::ST_IDLE))
        else $error("key schedule did not close cleanly");

    // The last schedule step is reached only after the whole S-box is swept.
    a_sched_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4ks_pkg::ST_KS_FIN) |-> (n_reg == '0 && pend_reg))
        else $error("key schedule left the sweep early");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the RC4 keystream cipher engine. A directed table
// covers the start-up state, the extremes of the data byte, every operation,
// ignored codes, short keys and S-box inversion. A long random run
// of keys, crypt bursts, inversions and noise follows. Every result is checked
// against a mirror of the S-box, key store and generator indexes kept here.
// ============================================================================
module testbench;

    // Operation code three has no meaning and must be dropped by the engine.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int TARGET_ITEMS  = 2000;
    localparam int HOLD_CYCLES   = 400;
    // Settle for longer than a key schedule runs.
    localparam int SETTLE_CYCLES = 1000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       last_key_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;

    rc4_keystream_cipher i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .data_byte     (data_byte),
        .last_key_byte (last_key_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte)
    );

    // ------------------------------------------------------------------------
    // Clock and a generous overall time limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Mirror of the engine state. It is updated at the moment each input
    // transaction is accepted, so its order follows the engine exactly.
    // ------------------------------------------------------------------------
    logic [7:0]                   mirror_sbox [rc4ks_pkg::SBOX_SIZE];
    logic [7:0]                   mirror_key [rc4ks_pkg::KEY_DEPTH];
    logic [rc4ks_pkg::KEY_CW-1:0] mirror_key_count;
    logic [7:0]                   mirror_i;
    logic [7:0]                   mirror_j;

    // Cipher bytes still owed by the engine, oldest first.
    logic [7:0] owed_cipher_bytes [$];

    // Run statistics for the closing summary.
    int unsigned counted_items;
    int unsigned crypt_count;
    int unsigned schedule_count;
    int unsigned overflow_loads;
    int unsigned invert_count;
    int unsigned ignored_count;
    int unsigned checked_count;
    int unsigned error_count;

    // Sender burst control and the receiver hold-off handshake.
    int unsigned sender_burst_left;
    int unsigned hold_requested;
    int unsigned hold_served;

    // Applies one accepted transaction to the mirror. Returns 1 when the
    // transaction produces a cipher byte, which is passed back in cipher.
    function automatic bit mirror_step(input logic [1:0] op, input logic [7:0] data,
                                       input logic last, output logic [7:0] cipher);
        logic [7:0] swap;
        logic [7:0] sched_j;
        int         kpos;
        cipher = 8'h00;
        case (op)
            rc4ks_pkg::OP_LOAD:
            begin
                if (mirror_key_count < rc4ks_pkg::KEY_DEPTH)
                begin
                    mirror_key[mirror_key_count] = data;
                    mirror_key_count = mirror_key_count + 1'b1;
                end
                if (last)
                begin
                    // The schedule always starts again from the identity.
                    for (int n = 0; n < rc4ks_pkg::SBOX_SIZE; n++)
                        mirror_sbox[n] = n[7:0];
                    sched_j = 8'h00;
                    kpos = 0;
                    for (int n = 0; n < rc4ks_pkg::SBOX_SIZE; n++)
                    begin
                        sched_j = sched_j + mirror_sbox[n] + mirror_key[kpos];
                        swap = mirror_sbox[n];
                        mirror_sbox[n] = mirror_sbox[sched_j];
                        mirror_sbox[sched_j] = swap;
                        kpos++;
                        if (kpos >= mirror_key_count)
                            kpos = 0;
                    end
                    mirror_i = 8'h00;
                    mirror_j = 8'h00;
                    mirror_key_count = '0;
                end
                return 1'b0;
            end
            rc4ks_pkg::OP_CRYPT:
            begin
                mirror_i = mirror_i + 8'd1;
                mirror_j = mirror_j + mirror_sbox[mirror_i];
                swap = mirror_sbox[mirror_i];
                mirror_sbox[mirror_i] = mirror_sbox[mirror_j];
                mirror_sbox[mirror_j] = swap;
                cipher = data ^ mirror_sbox[8'(mirror_sbox[mirror_i] + mirror_sbox[mirror_j])];
                return 1'b1;
            end
            rc4ks_pkg::OP_INVERT:
            begin
                for (int n = 0; n < rc4ks_pkg::SBOX_SIZE; n++)
                    mirror_sbox[n] = ~mirror_sbox[n];
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Each call offers one transaction, preceded by an idle gap of
    // random length, possibly none, when the current burst has run out, and
    // returns at the accepting edge with valid still high, so a following
    // call can keep valid up without a dip. During the gap the payload is noise.
    // ------------------------------------------------------------------------
    task automatic send_transaction(input logic [1:0] op, input logic [7:0] data,
                                    input logic last, input logic known,
                                    input logic [7:0] known_cipher);
        int unsigned gap;
        logic [7:0]  predicted;
        bit          produces;
        gap = 0;
        if (sender_burst_left == 0)
        begin
            sender_burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        sender_burst_left--;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid      <= 1'b0;
            operation     <= 2'($urandom_range(0, 3));
            data_byte     <= 8'($urandom_range(0, 255));
            last_key_byte <= 1'($urandom_range(0, 1));
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        operation     <= op;
        data_byte     <= data;
        last_key_byte <= last;
        do
            @(posedge clk);
        while (in_stall);

        // The transaction was taken at this edge.
        if (op == rc4ks_pkg::OP_LOAD && mirror_key_count == rc4ks_pkg::KEY_DEPTH)
            overflow_loads++;
        produces = mirror_step(op, data, last, predicted);
        if (produces)
            owed_cipher_bytes.push_back(known ? known_cipher : predicted);
        case (op)
            rc4ks_pkg::OP_LOAD:   if (last) schedule_count++;
            rc4ks_pkg::OP_CRYPT:  crypt_count++;
            rc4ks_pkg::OP_INVERT: invert_count++;
            default:              ignored_count++;
        endcase
        if (op != OP_UNUSED)
            counted_items++;
    endtask

    // Lowers valid and waits until the engine has delivered everything owed.
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_cipher_bytes.size() != 0)
            @(posedge clk);
    endtask

    // A crypt burst of random content, used both by the random part and
    // while the receiver is holding off.
    task automatic send_crypt_burst(input int unsigned count);
        repeat (count)
            send_transaction(rc4ks_pkg::OP_CRYPT, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'b0, 8'h00);
    endtask

    // A key of the given length with the last flag on its final byte only.
    task automatic send_key(input int unsigned length);
        for (int unsigned k = 1; k <= length; k++)
            send_transaction(rc4ks_pkg::OP_LOAD, 8'($urandom_range(0, 255)),
                             (k == length), 1'b0, 8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Stall probability changes in phases of random length, one
    // phase never stalling. A hold-off request from the stimulus makes it
    // stall solidly until its hold count runs out, which fills the engine.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned stall_pct;
        int unsigned phase_left;
        int unsigned hold_left;
        stall_pct  = 0;
        phase_left = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requested)
            begin
                hold_served = hold_requested;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(16, 160);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                phase_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Every accepted output transaction must match the oldest
    // cipher byte owed; a result with nothing owed is an error as well.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_cipher_bytes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got out_byte %02h",
                         $time, out_byte);
                error_count++;
            end
            else
            begin
                if (out_byte !== owed_cipher_bytes[0])
                begin
                    $display("%0t: out_byte mismatch, expected %02h, got %02h",
                             $time, owed_cipher_bytes[0], out_byte);
                    error_count++;
                end
                void'(owed_cipher_bytes.pop_front());
                checked_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table. Expected bytes are typed in only for the first two
    // crypt transactions after reset, where the S-box is still the identity:
    // the keystream bytes are then 2 and 5. All other rows use the mirror.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       last;
        logic       known;
        logic [7:0] cipher;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;
    directed_row_t directed_rows [DIRECTED_ROWS];

    // ------------------------------------------------------------------------
    // Main stimulus.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned pick;
        int unsigned next_long_key;
        int unsigned next_hold;

        rst_n             = 1'b0;
        in_valid          = 1'b0;
        operation         = rc4ks_pkg::OP_LOAD;
        data_byte         = 8'h00;
        last_key_byte     = 1'b0;
        counted_items     = 0;
        crypt_count       = 0;
        schedule_count    = 0;
        overflow_loads    = 0;
        invert_count      = 0;
        ignored_count     = 0;
        checked_count     = 0;
        error_count       = 0;
        sender_burst_left = 0;
        hold_requested    = 0;
        hold_served       = 0;
        mirror_key_count  = '0;
        mirror_i          = 8'h00;
        mirror_j          = 8'h00;
        for (int n = 0; n < rc4ks_pkg::SBOX_SIZE; n++)
            mirror_sbox[n] = n[7:0];
        for (int n = 0; n < rc4ks_pkg::KEY_DEPTH; n++)
            mirror_key[n] = 8'h00;

        directed_rows = '{
            // Start-up state: identity S-box.
            '{rc4ks_pkg::OP_CRYPT,  8'h00, 1'b0, 1'b1, 8'h02},
            '{rc4ks_pkg::OP_CRYPT,  8'hFF, 1'b0, 1'b1, 8'hFA},
            // Unused code with the flag set changes nothing.
            '{OP_UNUSED,            8'hAA, 1'b1, 1'b0, 8'h00},
            // Last flag on a crypt and an inversion is ignored.
            '{rc4ks_pkg::OP_CRYPT,  8'h5A, 1'b1, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_INVERT, 8'h00, 1'b1, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'h80, 1'b0, 1'b0, 8'h00},
            // Three-byte key with extreme bytes.
            '{rc4ks_pkg::OP_LOAD,   8'h00, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_LOAD,   8'hFF, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_LOAD,   8'h01, 1'b1, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'h00, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'hFF, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'h55, 1'b0, 1'b0, 8'h00},
            // Single-byte key.
            '{rc4ks_pkg::OP_LOAD,   8'hA5, 1'b1, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'h00, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'hAA, 1'b0, 1'b0, 8'h00},
            // Inversions between crypts, keeping i and j.
            '{rc4ks_pkg::OP_INVERT, 8'hFF, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'h0F, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_INVERT, 8'h00, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'hF0, 1'b0, 1'b0, 8'h00},
            '{OP_UNUSED,            8'h00, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'hFF, 1'b0, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_LOAD,   8'h3C, 1'b1, 1'b0, 8'h00},
            '{rc4ks_pkg::OP_CRYPT,  8'h00, 1'b0, 1'b0, 8'h00}
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
            send_transaction(directed_rows[r].op, directed_rows[r].data,
                             directed_rows[r].last, directed_rows[r].known,
                             directed_rows[r].cipher);
        pause_until_drained();

        // Random part: mostly well-formed keys followed by crypt bursts, with
        // inversions, noise, unfinished keys and drains mixed in. Two keys
        // fill the key store, one of them overflowing it, and twice the
        // receiver holds off while crypt transactions keep coming.
        next_long_key = 500;
        next_hold     = 300;
        while (counted_items < TARGET_ITEMS)
        begin
            if (counted_items >= next_hold)
            begin
                next_hold = (next_hold < 1000) ? 1600 : TARGET_ITEMS * 4;
                hold_requested++;
                sender_burst_left = 40;
                send_crypt_burst(40);
            end
            else if (counted_items >= next_long_key)
            begin
                if (next_long_key < 1000)
                begin
                    next_long_key = 1300;
                    send_key(rc4ks_pkg::KEY_DEPTH);
                end
                else
                begin
                    next_long_key = TARGET_ITEMS * 4;
                    send_key(rc4ks_pkg::KEY_DEPTH + $urandom_range(1, 12));
                end
                send_crypt_burst($urandom_range(5, 20));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    send_crypt_burst($urandom_range(1, 40));
                else if (pick < 70)
                    send_key($urandom_range(1, 16));
                else if (pick < 76)
                    send_transaction(rc4ks_pkg::OP_INVERT, 8'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1)), 1'b0, 8'h00);
                else if (pick < 82)
                begin
                    // Noise: any code, any flag, even a lone flagged load.
                    repeat ($urandom_range(1, 4))
                        send_transaction(2'($urandom_range(0, 3)),
                                         8'($urandom_range(0, 255)),
                                         1'($urandom_range(0, 1)), 1'b0, 8'h00);
                end
                else if (pick < 88)
                begin
                    // Key bytes with no closing flag: the next key grows.
                    repeat ($urandom_range(1, 5))
                        send_transaction(rc4ks_pkg::OP_LOAD, 8'($urandom_range(0, 255)),
                                         1'b0, 1'b0, 8'h00);
                end
                else if (pick < 92)
                    pause_until_drained();
                else
                begin
                    repeat ($urandom_range(1, 6))
                        send_transaction(rc4ks_pkg::OP_CRYPT,
                                         ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                                         1'b0, 1'b0, 8'h00);
                end
            end
        end

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d crypt, %0d key schedules, %0d loads into a full key store,",
                 crypt_count, schedule_count, overflow_loads);
        $display("%0d inversions and %0d unused codes; %0d cipher bytes checked, %0d errors.",
                 invert_count, ignored_count, checked_count, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### rc4_keystream_cipher.f
src/rc4ks_pkg.sv
src/rc4ks_sbox.sv
src/rc4_keystream_cipher.sv
verif/testbench.sv
